FILE: sv/wulr_pkg.sv
// Shared types and constants for the antialiased line engine.
package wulr_pkg;

  localparam int ACC_BITS = 16;
  localparam int DCNT_BITS = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 13;
  localparam int PX_BITS = 14;
  localparam int PY_BITS = 13;
  localparam int ADDR_BITS = 24;
  localparam int LIN_BITS = 26;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HORIZ = 3'd1;
  localparam logic [2:0] PH_VERT = 3'd2;
  localparam logic [2:0] PH_DIAG = 3'd3;
  localparam logic [2:0] PH_PAIRS = 3'd4;
  localparam logic [2:0] PH_FINAL = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANAR = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IBITS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVELS = 3'd4;

  localparam logic REQ_START = 1'b0;

  typedef struct packed {
    logic start;
    logic tick;
    logic emit2;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_pairs;
    logic div_busy;
    logic pair_tick;
  } stat_t;

endpackage

FILE: sv/wulr_ctrl.sv
// Controller state machine for the antialiased line engine.
module wulr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_stall,
  input  wulr_pkg::stat_t stat,
  output wulr_pkg::cmd_t  cmd
);
  import wulr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_PAIR2 = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  always_comb begin
    in_stall = 1'b1;
    if (state_r == S_IDLE) begin
      in_stall = !stat.out_free;
    end
  end

  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_req_type == REQ_START) begin
          cmd.start = 1'b1;
          if (stat.start_pairs) begin
            state_nxt = S_DIV;
          end
        end else if (acc) begin
          cmd.tick = 1'b1;
          if (stat.pair_tick) begin
            state_nxt = S_PAIR2;
          end
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_PAIR2: begin
        if (stat.out_free) begin
          cmd.emit2 = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> ((state_r == S_DIV) == $past(stat.start_pairs)))
    else $error("divide state does not follow a start of a weighted line");
  a_busy_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !(cmd.start || cmd.tick))
    else $error("word accepted while the engine is busy");
  a_emit2_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit2 |=> (state_r == S_IDLE))
    else $error("second pixel of a pair not followed by idle");

endmodule

FILE: sv/wulr_dp.sv
// Datapath of the antialiased line engine: line state, divider and pixel output stage.
module wulr_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [wulr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wulr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [COORD_BITS-1:0]                in_start_x,
  input  logic [COORD_BITS-1:0]                in_start_y,
  input  logic [COORD_BITS-1:0]                in_end_x,
  input  logic [COORD_BITS-1:0]                in_end_y,
  input  logic [7:0]                           in_base_color,
  input  wulr_pkg::cmd_t                       cmd,
  output wulr_pkg::stat_t                      stat,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [wulr_pkg::PX_BITS-1:0]  out_pixel_x,
  output logic [wulr_pkg::PY_BITS-1:0]         out_pixel_y,
  output logic [7:0]                           out_pixel_color,
  output logic                                 out_visible,
  output logic [wulr_pkg::ADDR_BITS-1:0]       out_pixel_address,
  output logic [3:0]                           out_plane_mask,
  output logic                                 out_last_of_item,
  output logic                                 out_line_done
);
  import wulr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + 1;
  localparam int VW = (CW + 1 > 14) ? CW + 1 : 14;

  logic [12:0] cfg_w_r, cfg_h_r;
  logic        cfg_planar_r;
  logic [3:0]  cfg_ib_r;
  logic [8:0]  cfg_lev_r;

  logic              active_r, active_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [CW-1:0]     cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CB-1:0]     fin_x_r, fin_x_nxt, fin_y_r, fin_y_nxt;
  logic [CB-1:0]     steps_r, steps_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt, adj_r, adj_nxt;
  logic              xneg_r, xneg_nxt, ymaj_r, ymaj_nxt;
  logic [7:0]        color_r, color_nxt, col2_r, col2_nxt;
  logic [CB-1:0]     rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DCNT_BITS-1:0] dcnt_r, dcnt_nxt;

  // Start decode.
  logic          swap;
  logic [CB-1:0] x0, y0, x1, y1, adx, dy, major, minor, s_steps;
  logic [CB:0]   dxs;
  logic [2:0]    s_phase;
  logic          s_neg;

  always_comb begin
    swap = in_start_y > in_end_y;
    x0 = swap ? in_end_x : in_start_x;
    y0 = swap ? in_end_y : in_start_y;
    x1 = swap ? in_start_x : in_end_x;
    y1 = swap ? in_start_y : in_end_y;
    dxs = {1'b0, x1} - {1'b0, x0};
    s_neg = dxs[CB];
    adx = s_neg ? CB'(-dxs) : dxs[CB-1:0];
    dy = y1 - y0;
    major = (dy > adx) ? dy : adx;
    minor = (dy > adx) ? adx : dy;
    if (dy == '0) begin
      s_phase = PH_HORIZ;
      s_steps = adx;
    end else if (adx == '0) begin
      s_phase = PH_VERT;
      s_steps = dy;
    end else if (adx == dy) begin
      s_phase = PH_DIAG;
      s_steps = dy;
    end else begin
      s_phase = PH_PAIRS;
      s_steps = major - CB'(1);
    end
  end

  // Tick arithmetic.
  logic [CW-1:0]       dir, t_x, t_y, p2_x, p2_y;
  logic [ACC_BITS:0]   sum;
  logic [ACC_BITS-1:0] nacc, w, cmp;
  logic                wrap;
  logic [4:0]          shift;
  logic [CB-1:0]       steps_dec;

  always_comb begin
    dir = xneg_r ? '1 : CW'(1);
    sum = {1'b0, acc_r} + {1'b0, adj_r};
    nacc = sum[ACC_BITS-1:0];
    wrap = nacc <= acc_r;
    shift = 5'(ACC_BITS) - {1'b0, cfg_ib_r};
    w = nacc >> shift;
    cmp = (cfg_lev_r == '0) ? '1 : ACC_BITS'(cfg_lev_r - 9'd1);
    steps_dec = steps_r - CB'(1);
    t_x = cur_x_r;
    t_y = cur_y_r;
    if (phase_r == PH_PAIRS) begin
      if (ymaj_r) begin
        t_y = cur_y_r + CW'(1);
        if (wrap) t_x = cur_x_r + dir;
      end else begin
        t_x = cur_x_r + dir;
        if (wrap) t_y = cur_y_r + CW'(1);
      end
    end else begin
      if (phase_r != PH_VERT) t_x = cur_x_r + dir;
      if (phase_r != PH_HORIZ) t_y = cur_y_r + CW'(1);
    end
    p2_x = ymaj_r ? cur_x_r + dir : cur_x_r;
    p2_y = ymaj_r ? cur_y_r : cur_y_r + CW'(1);
  end

  // Pixel selection.
  logic                emit;
  logic signed [CW:0]  e_x;
  logic [CW-1:0]       e_y;
  logic [7:0]          e_col;
  logic                e_last, e_done;

  always_comb begin
    emit = cmd.start || cmd.emit2 || (cmd.tick && active_r);
    e_x = $signed({1'b0, cur_x_r});
    e_y = cur_y_r;
    e_col = color_r;
    e_last = 1'b1;
    e_done = 1'b0;
    if (cmd.start) begin
      e_x = $signed({2'b00, x0});
      e_y = {1'b0, y0};
      e_col = in_base_color;
      e_done = s_steps == '0;
    end else if (cmd.emit2) begin
      e_x = ($signed({1'b0, cur_x_r}) + (xneg_r ? -(CW+1)'(1) : (CW+1)'(1)));
      if (!ymaj_r) e_x = $signed({1'b0, cur_x_r});
      e_y = p2_y;
      e_col = col2_r;
    end else if (phase_r == PH_FINAL) begin
      e_x = $signed({2'b00, fin_x_r});
      e_y = {1'b0, fin_y_r};
      e_done = 1'b1;
    end else if (phase_r == PH_PAIRS) begin
      e_x = $signed({1'b0, t_x});
      e_y = t_y;
      e_col = color_r + w[7:0];
      e_last = 1'b0;
    end else begin
      e_x = $signed({1'b0, t_x});
      e_y = t_y;
      e_done = steps_dec == '0;
    end
  end

  logic                 vis;
  logic [12:0]          ex13, ey13;
  logic [LIN_BITS-1:0]  lin;

  always_comb begin
    vis = !e_x[CW] && (VW'($unsigned(e_x)) < VW'(cfg_w_r))
          && (VW'(e_y) < VW'(cfg_h_r));
    ex13 = 13'($unsigned(e_x));
    ey13 = 13'(e_y);
    lin = LIN_BITS'(ey13) * LIN_BITS'(cfg_w_r) + LIN_BITS'(ex13);
  end

  // State update.
  always_comb begin
    active_nxt = active_r;
    phase_nxt = phase_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    fin_x_nxt = fin_x_r;
    fin_y_nxt = fin_y_r;
    steps_nxt = steps_r;
    acc_nxt = acc_r;
    adj_nxt = adj_r;
    xneg_nxt = xneg_r;
    ymaj_nxt = ymaj_r;
    color_nxt = color_r;
    col2_nxt = col2_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    dcnt_nxt = dcnt_r;
    if (cmd.start) begin
      color_nxt = in_base_color;
      cur_x_nxt = {1'b0, x0};
      cur_y_nxt = {1'b0, y0};
      fin_x_nxt = x1;
      fin_y_nxt = y1;
      xneg_nxt = s_neg;
      acc_nxt = '0;
      adj_nxt = '0;
      ymaj_nxt = (s_phase == PH_PAIRS) && (dy > adx);
      steps_nxt = s_steps;
      active_nxt = s_steps != '0;
      phase_nxt = (s_steps != '0) ? s_phase : PH_IDLE;
      if (s_phase == PH_PAIRS) begin
        rem_nxt = minor;
        dvs_nxt = major;
        dcnt_nxt = DCNT_BITS'(ACC_BITS);
      end
    end else if (dcnt_r != '0) begin
      dcnt_nxt = dcnt_r - DCNT_BITS'(1);
      if ({rem_r, 1'b0} >= {1'b0, dvs_r}) begin
        rem_nxt = CB'({rem_r, 1'b0} - {1'b0, dvs_r});
        adj_nxt = {adj_r[ACC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[CB-2:0], 1'b0};
        adj_nxt = {adj_r[ACC_BITS-2:0], 1'b0};
      end
    end else if (cmd.tick && active_r) begin
      if (phase_r == PH_FINAL) begin
        active_nxt = 1'b0;
        phase_nxt = PH_IDLE;
        steps_nxt = '0;
      end else begin
        cur_x_nxt = t_x;
        cur_y_nxt = t_y;
        steps_nxt = steps_dec;
        if (phase_r == PH_PAIRS) begin
          acc_nxt = nacc;
          col2_nxt = color_r + 8'(w ^ cmp);
          if (steps_dec == '0) phase_nxt = PH_FINAL;
        end else if (steps_dec == '0) begin
          active_nxt = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_comb begin
    stat.out_free = !out_valid || !out_stall;
    stat.start_pairs = s_phase == PH_PAIRS;
    stat.div_busy = dcnt_r != '0;
    stat.pair_tick = active_r && (phase_r == PH_PAIRS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 13'd320;
      cfg_h_r <= 13'd240;
      cfg_planar_r <= 1'b1;
      cfg_ib_r <= 4'd8;
      cfg_lev_r <= 9'd256;
      active_r <= 1'b0;
      phase_r <= PH_IDLE;
      dcnt_r <= '0;
      out_valid <= 1'b0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      fin_x_r <= '0;
      fin_y_r <= '0;
      steps_r <= '0;
      acc_r <= '0;
      adj_r <= '0;
      xneg_r <= 1'b0;
      ymaj_r <= 1'b0;
      color_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WIDTH: cfg_w_r <= cfg_data;
          REG_HEIGHT: cfg_h_r <= cfg_data;
          REG_PLANAR: cfg_planar_r <= cfg_data[0];
          REG_IBITS: cfg_ib_r <= cfg_data[3:0];
          REG_LEVELS: cfg_lev_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      active_r <= active_nxt;
      phase_r <= phase_nxt;
      dcnt_r <= dcnt_nxt;
      out_valid <= emit || (out_valid && out_stall);
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      fin_x_r <= fin_x_nxt;
      fin_y_r <= fin_y_nxt;
      steps_r <= steps_nxt;
      acc_r <= acc_nxt;
      adj_r <= adj_nxt;
      xneg_r <= xneg_nxt;
      ymaj_r <= ymaj_nxt;
      color_r <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col2_r <= col2_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (emit) begin
      out_pixel_x <= PX_BITS'(e_x);
      out_pixel_y <= PY_BITS'(e_y);
      out_pixel_color <= e_col;
      out_visible <= vis;
      out_last_of_item <= e_last;
      out_line_done <= e_done;
      out_pixel_address <= '0;
      out_plane_mask <= '0;
      if (vis && cfg_planar_r) begin
        out_pixel_address <= lin[ADDR_BITS+1:2];
        out_plane_mask <= 4'b0001 << lin[1:0];
      end else if (vis) begin
        out_pixel_address <= lin[ADDR_BITS-1:0];
      end
    end
  end

endmodule

FILE: sv/wu_antialiased_line_rasterizer_core.sv
// Top level of the antialiased line engine: controller plus datapath.
//
//  Channel | Direction | Handshake         | Contents
//  in_     | input     | in_valid/in_stall | request type, endpoints, base color
//  out_    | output    | out_valid/out_stall | one pixel word
//  cfg_    | input     | cfg_valid/cfg_ready | register index and data
//
// A start word for a weighted line also runs the bit-serial divider, and the
// input stalls until it is done. A tick on a weighted line gives a pixel pair,
// one word at a time through the single output register. Reset is synchronous and
// restores the register defaults with no line active. A stalled output holds
// its word and stalls the input.
module wu_antialiased_line_rasterizer_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wulr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wulr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [COORD_BITS-1:0]                in_start_x,
  input  logic [COORD_BITS-1:0]                in_start_y,
  input  logic [COORD_BITS-1:0]                in_end_x,
  input  logic [COORD_BITS-1:0]                in_end_y,
  input  logic [7:0]                           in_base_color,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wulr_pkg::PX_BITS-1:0]  out_pixel_x,
  output logic [wulr_pkg::PY_BITS-1:0]         out_pixel_y,
  output logic [7:0]                           out_pixel_color,
  output logic                                 out_visible,
  output logic [wulr_pkg::ADDR_BITS-1:0]       out_pixel_address,
  output logic [3:0]                           out_plane_mask,
  output logic                                 out_last_of_item,
  output logic                                 out_line_done
);
  import wulr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  wulr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  wulr_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_base_color    (in_base_color),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_visible      (out_visible),
    .out_pixel_address(out_pixel_address),
    .out_plane_mask   (out_plane_mask),
    .out_last_of_item (out_last_of_item),
    .out_line_done    (out_line_done)
  );

endmodule

FILE: dv/tb_wu_antialiased_line_rasterizer_core.sv
// Testbench for the antialiased line engine: directed table, random line sequences, self-check.
module tb_wu_antialiased_line_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wulr_pkg::*;

  typedef struct packed {
    logic [13:0] px;
    logic [12:0] py;
    logic [7:0]  color;
    logic        vis;
    logic [23:0] addr;
    logic [3:0]  mask;
    logic        last;
    logic        done;
  } pixel_t;

  typedef struct {
    logic        req;
    logic [11:0] sx, sy, ex, ey;
    logic [7:0]  color;
    bit          has_exp;
    pixel_t      exp_px;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic in_req_type = 0;
  logic [11:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic [7:0] in_base_color = 0;
  logic out_valid, out_stall = 0;
  logic signed [PX_BITS-1:0] out_pixel_x;
  logic [PY_BITS-1:0] out_pixel_y;
  logic [7:0] out_pixel_color;
  logic out_visible;
  logic [ADDR_BITS-1:0] out_pixel_address;
  logic [3:0] out_plane_mask;
  logic out_last_of_item, out_line_done;

  wu_antialiased_line_rasterizer_core #(.COORD_BITS(12)) dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Predictor state and configuration.
  int unsigned scr_w, scr_h, planar, ibits, levels;
  bit          busy, yfirst, xneg;
  logic [2:0]  ph;
  int          px_cur, py_cur, px_end, py_end;
  int unsigned steps, acc, adj, color_reg;

  pixel_t pixel_q[$];
  pixel_t first_px;
  int errors = 0, n_items = 0, n_pixels = 0, n_lines = 0;

  function automatic void emit_pixel(int x, int y, int unsigned c, bit last, bit done);
    pixel_t p;
    int unsigned lin;
    p.vis = x >= 0 && y >= 0 && x < scr_w && y < scr_h;
    p.addr = '0;
    p.mask = '0;
    if (p.vis) begin
      lin = y * scr_w + x;
      if (planar[0]) begin
        p.mask = 4'(1 << (lin & 3));
        p.addr = 24'(lin >> 2);
      end else begin
        p.addr = 24'(lin);
      end
    end
    p.px = 14'(x);
    p.py = 13'(y);
    p.color = 8'(c);
    p.last = last;
    p.done = done;
    pixel_q.push_back(p);
    n_pixels++;
  endfunction

  function automatic void predict_pixels(logic req, int x0, int y0, int x1, int y1,
                                         logic [7:0] c);
    int t, dx, dy, dir;
    int unsigned major, minor, shift, cmp, old, w;
    if (req == REQ_START) begin
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
        t = x0; x0 = x1; x1 = t;
      end
      color_reg = c;
      px_cur = x0; py_cur = y0; px_end = x1; py_end = y1;
      dx = x1 - x0;
      xneg = dx < 0;
      if (dx < 0) dx = -dx;
      dy = y1 - y0;
      acc = 0; adj = 0; yfirst = 0; busy = 1;
      if (dy == 0) begin
        ph = PH_HORIZ; steps = dx;
      end else if (dx == 0) begin
        ph = PH_VERT; steps = dy;
      end else if (dx == dy) begin
        ph = PH_DIAG; steps = dy;
      end else begin
        yfirst = dy > dx;
        major = yfirst ? dy : dx;
        minor = yfirst ? dx : dy;
        adj = ((minor << 16) / major) & 16'hFFFF;
        ph = PH_PAIRS;
        steps = major - 1;
      end
      if (steps == 0) begin
        busy = 0; ph = PH_IDLE;
      end
      n_lines++;
      emit_pixel(x0, y0, color_reg, 1, !busy);
      first_px = pixel_q[$];
      return;
    end
    if (!busy) return;
    dir = xneg ? -1 : 1;
    if (ph == PH_HORIZ || ph == PH_VERT || ph == PH_DIAG) begin
      if (ph != PH_VERT) px_cur += dir;
      if (ph != PH_HORIZ) py_cur += 1;
      steps--;
      if (steps == 0) begin
        busy = 0; ph = PH_IDLE;
      end
      emit_pixel(px_cur, py_cur, color_reg, 1, !busy);
    end else if (ph == PH_PAIRS) begin
      shift = ibits >= 16 ? 0 : 16 - ibits;
      cmp = (levels - 1) & 16'hFFFF;
      old = acc;
      acc = (acc + adj) & 16'hFFFF;
      if (acc <= old) begin
        if (yfirst) px_cur += dir; else py_cur += 1;
      end
      if (yfirst) py_cur += 1; else px_cur += dir;
      w = acc >> shift;
      emit_pixel(px_cur, py_cur, color_reg + w, 0, 0);
      if (yfirst) emit_pixel(px_cur + dir, py_cur, color_reg + (w ^ cmp), 1, 0);
      else emit_pixel(px_cur, py_cur + 1, color_reg + (w ^ cmp), 1, 0);
      steps--;
      if (steps == 0) ph = PH_FINAL;
    end else begin
      busy = 0; ph = PH_IDLE; steps = 0;
      emit_pixel(px_end, py_end, color_reg, 1, 1);
    end
  endfunction

  // Result side: random stall per word, compare with the oldest expected pixel.
  int stall_left = 0;
  always @(posedge clk) begin
    pixel_t e;
    int n;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d", out_pixel_x, out_pixel_y);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_pixel_x !== e.px) begin
          $error("pixel_x exp %0h got %0h", e.px, out_pixel_x); errors++;
        end
        if (out_pixel_y !== e.py) begin
          $error("pixel_y exp %0h got %0h", e.py, out_pixel_y); errors++;
        end
        if (out_pixel_color !== e.color) begin
          $error("pixel_color exp %0h got %0h", e.color, out_pixel_color); errors++;
        end
        if (out_visible !== e.vis) begin
          $error("visible exp %0h got %0h", e.vis, out_visible); errors++;
        end
        if (out_pixel_address !== e.addr) begin
          $error("pixel_address exp %0h got %0h", e.addr, out_pixel_address); errors++;
        end
        if (out_plane_mask !== e.mask) begin
          $error("plane_mask exp %0h got %0h", e.mask, out_plane_mask); errors++;
        end
        if (out_last_of_item !== e.last) begin
          $error("last_of_item exp %0h got %0h", e.last, out_last_of_item); errors++;
        end
        if (out_line_done !== e.done) begin
          $error("line_done exp %0h got %0h", e.done, out_line_done); errors++;
        end
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      stall_left = n;
      out_stall <= (n > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_WIDTH:  scr_w = val & 13'h1FFF;
      REG_HEIGHT: scr_h = val & 13'h1FFF;
      REG_PLANAR: planar = val & 1;
      REG_IBITS:  ibits = val & 4'hF;
      REG_LEVELS: levels = val & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_word(logic req, logic [11:0] sx, sy, ex, ey, logic [7:0] c);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    in_base_color <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_pixels(req, sx, sy, ex, ey, c);
    n_items++;
  endtask

  function automatic pixel_t pix(int x, int y, int c, int a, int m, bit l, bit d);
    pixel_t p;
    p.px = 14'(x); p.py = 13'(y); p.color = 8'(c); p.vis = 1;
    p.addr = 24'(a); p.mask = 4'(m); p.last = l; p.done = d;
    return p;
  endfunction

  function automatic logic [11:0] near(logic [11:0] v);
    int r;
    r = int'(v) + $urandom_range(0, 40) - 20;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return 12'(r);
  endfunction

  row_t rows[$];

  initial begin
    row_t r;
    int lines_done, len, ticks;
    logic [11:0] sx, sy, ex, ey;
    bit tiny;
    scr_w = 320; scr_h = 240; planar = 1; ibits = 8; levels = 256;
    busy = 0; ph = PH_IDLE; px_cur = 0; py_cur = 0; px_end = 0; py_end = 0;
    steps = 0; acc = 0; adj = 0; xneg = 0; yfirst = 0; color_reg = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    r = '{default: 0};
    r.req = 1; rows.push_back(r);
    r = '{req: 0, sx: 0, sy: 0, ex: 0, ey: 0, color: 5, has_exp: 1,
          exp_px: pix(0, 0, 5, 0, 1, 1, 1)};
    rows.push_back(r);
    r = '{req: 0, sx: 7, sy: 2, ex: 3, ey: 2, color: 255, has_exp: 1,
          exp_px: pix(7, 2, 255, 161, 8, 1, 0)};
    rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    repeat (4) rows.push_back(r);
    r = '{req: 0, sx: 10, sy: 9, ex: 10, ey: 5, color: 8'h80, default: 0}; rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    repeat (4) rows.push_back(r);
    r = '{req: 0, sx: 4, sy: 4, ex: 1, ey: 7, color: 1, default: 0}; rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    rows.push_back(r);
    r = '{req: 0, sx: 20, sy: 1, ex: 3, ey: 6, color: 9, default: 0}; rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    repeat (3) rows.push_back(r);
    r = '{req: 0, sx: 4095, sy: 4095, ex: 0, ey: 0, color: 8'hAA, default: 0};
    rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    rows.push_back(r);
    r = '{req: 0, sx: 0, sy: 4095, ex: 4095, ey: 4092, color: 8'h55, default: 0};
    rows.push_back(r);
    r = '{default: 0}; r.req = 1;
    repeat (2) rows.push_back(r);

    foreach (rows[i]) begin
      send_word(rows[i].req, rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, rows[i].color);
      if (rows[i].has_exp && first_px !== rows[i].exp_px) begin
        $error("directed row %0d: exp %h got %h", i, rows[i].exp_px, first_px);
        errors++;
      end
    end

    lines_done = 0;
    while (n_items < 1750) begin
      if (lines_done % 25 == 0) begin
        settle();
        case ($urandom_range(0, 4))
          0: write_reg(REG_WIDTH, 1);
          1: write_reg(REG_WIDTH, 4096);
          2: write_reg(REG_WIDTH, 0);
          3: write_reg(REG_WIDTH, 8191);
          default: write_reg(REG_WIDTH, $urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 4))
          0: write_reg(REG_HEIGHT, 1);
          1: write_reg(REG_HEIGHT, 4096);
          2: write_reg(REG_HEIGHT, 0);
          3: write_reg(REG_HEIGHT, 8191);
          default: write_reg(REG_HEIGHT, $urandom_range(1, 4096));
        endcase
        write_reg(REG_PLANAR, $urandom_range(0, 1));
        write_reg(REG_IBITS, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                             : $urandom_range(1, 8));
        case ($urandom_range(0, 3))
          0: write_reg(REG_LEVELS, 0);
          1: write_reg(REG_LEVELS, 511);
          default: write_reg(REG_LEVELS, $urandom_range(1, 256));
        endcase
        cfg_valid <= 0;
      end
      tiny = $urandom_range(0, 9) != 0;
      sx = $urandom_range(0, 4095);
      sy = $urandom_range(0, 4095);
      if (tiny) begin
        ex = near(sx);
        ey = near(sy);
        if ($urandom_range(0, 5) == 0) ex = sx;
        if ($urandom_range(0, 5) == 0) ey = sy;
      end else begin
        ex = $urandom_range(0, 4095);
        ey = $urandom_range(0, 4095);
      end
      send_word(REQ_START, sx, sy, ex, ey, 8'($urandom));
      len = tiny ? 45 : 6;
      ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len;
      for (int k = 0; k < ticks && n_items < 1750; k++) begin
        if (!busy && $urandom_range(0, 3) != 0) break;
        send_word(~REQ_START, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 8'($urandom));
      end
      lines_done++;
    end
    in_valid <= 0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d input words, %0d lines and %0d pixel words over several settings.",
             n_items, n_lines, n_pixels);
    if (errors == 0) begin
      $display("[wu_antialiased_line_rasterizer_core] OK");
    end else begin
      $display("[wu_antialiased_line_rasterizer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[wu_antialiased_line_rasterizer_core] ERROR");
    $finish;
  end

endmodule
